// ===== hdl/lbvs_pkg.sv =====
// Shared types, constants and helpers for the vertex skinning core.
`default_nettype none
package lbvs_pkg;

  typedef enum logic {
    OP_SKIN  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  localparam int INFLUENCES   = 4;
  localparam int STORED_WORDS = 13;
  localparam int TRANS_WORD   = 9;
  localparam int MARGIN_WORD  = 12;
  localparam int QUEUE_DEPTH  = 4;
  localparam int OUT_DEPTH    = 4;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [31:0] influence_bones;
    logic        [15:0] weight_a;
    logic        [15:0] weight_b;
    logic        [15:0] weight_c;
    logic        [15:0] weight_d;
    logic        [11:0] table_word_address;
    logic signed [31:0] table_word_value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] margin;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/linear_blend_vertex_skinning_core.sv =====
// Skinning reads one bone per cycle through the single bone-table read port;
// a new transaction can be taken while the last bone of the previous vertex is read.
// Reset: synchronous, active low; clears queues, pipeline valids, enables skinning.
// The bone table is not cleared; entries are undefined until written.
`default_nettype none
module linear_blend_vertex_skinning_core
  import lbvs_pkg::*;
#(
  parameter int BONE_SLOTS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [31:0] in_influence_bones,
  input  wire logic [15:0] in_weight_a,
  input  wire logic [15:0] in_weight_b,
  input  wire logic [15:0] in_weight_c,
  input  wire logic [15:0] in_weight_d,
  input  wire logic [11:0] in_table_word_address,
  input  wire logic [31:0] in_table_word_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_skinned_x,
  output logic [31:0]      out_skinned_y,
  output logic [31:0]      out_skinned_z,
  output logic [31:0]      out_skinned_margin
);

  item_t   in_item, f_item, q_item;
  result_t res;
  logic    f_valid, f_ready, q_valid, q_pop;

  always_comb begin
    in_item.operation          = op_t'(in_operation);
    in_item.pos_x              = in_pos_x;
    in_item.pos_y              = in_pos_y;
    in_item.pos_z              = in_pos_z;
    in_item.influence_bones    = in_influence_bones;
    in_item.weight_a           = in_weight_a;
    in_item.weight_b           = in_weight_b;
    in_item.weight_c           = in_weight_c;
    in_item.weight_d           = in_weight_d;
    in_item.table_word_address = in_table_word_address;
    in_item.table_word_value   = in_table_word_value;
  end

  lbvs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item)
  );

  lbvs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  lbvs_back #(.BONE_SLOTS(BONE_SLOTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (res)
  );

  assign out_skinned_x      = res.x;
  assign out_skinned_y      = res.y;
  assign out_skinned_z      = res.z;
  assign out_skinned_margin = res.margin;

endmodule
`default_nettype wire

// ===== hdl/lbvs_front.sv =====
// Front stage: accepts transactions, holds the enable register, drops disabled vertices.
`default_nettype none
module lbvs_front
  import lbvs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       push_valid,
  input  wire logic  push_ready,
  output item_t      push_item
);

  logic  en_r, en_nxt;
  logic  fv_r, fv_nxt;
  item_t item_r;
  logic  accept, keep;

  assign in_ready   = !fv_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign keep       = (in_item.operation == OP_WRITE) || en_r;
  assign push_valid = fv_r;
  assign push_item  = item_r;

  always_comb begin
    en_nxt = cfg_we ? cfg_wdata : en_r;
    if (accept) begin
      fv_nxt = keep;
    end else begin
      fv_nxt = fv_r && !push_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
      fv_r <= 1'b0;
    end else begin
      en_r <= en_nxt;
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lbvs_queue.sv =====
// Short queue between the front and back stages.
`default_nettype none
module lbvs_queue
  import lbvs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop,
  output item_t      pop_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t           store [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = cnt_r != (PW+1)'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = store[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wp_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lbvs_back.sv =====
// Back stage: bone table, influence sequencer, blend pipeline and result queue.
`default_nettype none
module lbvs_back
  import lbvs_pkg::*;
#(
  parameter int BONE_SLOTS = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire item_t q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_result
);

  localparam int BW = (BONE_SLOTS > 1) ? $clog2(BONE_SLOTS) : 1;
  localparam int OW = $clog2(OUT_DEPTH);

  // sequencer
  logic        busy_r, busy_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       cur_r;
  logic [OW:0] credit_r, credit_nxt;
  logic        can_take, is_skin, take_skin, out_fire;

  assign is_skin   = q_item.operation == OP_SKIN;
  assign can_take  = !busy_r || (cnt_r == 2'd3);
  assign q_pop     = q_valid && can_take &&
                     (!is_skin || (credit_r < (OW+1)'(OUT_DEPTH)));
  assign take_skin = q_pop && is_skin;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    credit_nxt = credit_r + (OW+1)'(take_skin) - (OW+1)'(out_fire);
    if (take_skin) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
    end else if (busy_r && cnt_r == 2'd3) begin
      busy_nxt = 1'b0;
      cnt_nxt  = 2'd0;
    end else begin
      busy_nxt = busy_r;
      cnt_nxt  = busy_r ? cnt_r + 2'd1 : cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= 2'd0;
      credit_r <= '0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      credit_r <= credit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_skin) begin
      cur_r <= q_item;
    end
  end

  // influence issue
  logic [7:0]    iss_bone;
  logic [15:0]   iss_weight;
  logic          iss_use;
  logic [BW-1:0] rbone;

  assign iss_bone = cur_r.influence_bones[8*cnt_r +: 8];
  assign iss_use  = 32'(iss_bone) < 32'(BONE_SLOTS);
  assign rbone    = iss_bone[BW-1:0];

  always_comb begin
    case (cnt_r)
      2'd0:    iss_weight = cur_r.weight_a;
      2'd1:    iss_weight = cur_r.weight_b;
      2'd2:    iss_weight = cur_r.weight_c;
      default: iss_weight = cur_r.weight_d;
    endcase
  end

  // bone table
  logic          we;
  logic [3:0]    wword;
  logic [7:0]    wbone8;
  logic [BW-1:0] wbone;
  logic [31:0]   rd_word [STORED_WORDS];
  logic [31:0]   mem [STORED_WORDS][BONE_SLOTS];

  assign wword  = q_item.table_word_address[3:0];
  assign wbone8 = q_item.table_word_address[11:4];
  assign wbone  = wbone8[BW-1:0];
  assign we     = q_pop && !is_skin && (32'(wword) < 32'(STORED_WORDS)) &&
                  (32'(wbone8) < 32'(BONE_SLOTS));

  always_ff @(posedge clk) begin
    for (int w = 0; w < STORED_WORDS; w++) begin
      if (we && wword == 4'(w)) begin
        mem[w][wbone] <= q_item.table_word_value;
      end
      rd_word[w] <= mem[w][rbone];
    end
  end

  // stage 1: table read
  logic               v1_r, first1_r, last1_r, use1_r;
  logic [15:0]        w1_r;
  logic signed [31:0] p1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= cnt_r == 2'd0;
    last1_r  <= cnt_r == 2'd3;
    use1_r   <= iss_use;
    w1_r     <= iss_weight;
    p1_r[0]  <= cur_r.pos_x;
    p1_r[1]  <= cur_r.pos_y;
    p1_r[2]  <= cur_r.pos_z;
  end

  // stage 2: matrix products
  logic               v2_r, first2_r, last2_r, use2_r;
  logic [15:0]        w2_r;
  logic signed [63:0] prod2_r [9];
  logic signed [31:0] t2_r [3];
  logic signed [31:0] m2_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int a = 0; a < 3; a++) begin
        prod2_r[k*3+a] <= $signed(rd_word[k*3+a]) * p1_r[k];
      end
      t2_r[k] <= $signed(rd_word[TRANS_WORD+k]);
    end
    m2_r     <= $signed(rd_word[MARGIN_WORD]);
    first2_r <= first1_r;
    last2_r  <= last1_r;
    use2_r   <= use1_r;
    w2_r     <= w1_r;
  end

  // stage 3: column sums
  logic               v3_r, first3_r, last3_r, use3_r;
  logic [15:0]        w3_r;
  logic signed [65:0] s3_r [3];
  logic signed [31:0] t3_r [3];
  logic signed [31:0] m3_r;

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      s3_r[a] <= 66'(prod2_r[a]) + 66'(prod2_r[3+a]) + 66'(prod2_r[6+a]);
      t3_r[a] <= t2_r[a];
    end
    m3_r     <= m2_r;
    first3_r <= first2_r;
    last3_r  <= last2_r;
    use3_r   <= use2_r;
    w3_r     <= w2_r;
  end

  // stage 4: round, translate, saturate
  logic               v4_r, first4_r, last4_r, use4_r;
  logic [15:0]        w4_r;
  logic signed [31:0] c4_r [INFLUENCES];
  logic signed [65:0] rnd3 [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rnd3[a] = (s3_r[a] + 66'sd32768) >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      c4_r[a] <= sat32(64'(rnd3[a]) + 64'(t3_r[a]));
    end
    c4_r[3]  <= m3_r;
    first4_r <= first3_r;
    last4_r  <= last3_r;
    use4_r   <= use3_r;
    w4_r     <= w3_r;
  end

  // stage 5: weight products
  logic               v5_r, first5_r, last5_r;
  logic signed [48:0] wp5_r [INFLUENCES];

  always_ff @(posedge clk) begin
    for (int a = 0; a < INFLUENCES; a++) begin
      wp5_r[a] <= use4_r ? c4_r[a] * $signed({1'b0, w4_r}) : 49'sd0;
    end
    first5_r <= first4_r;
    last5_r  <= last4_r;
  end

  // stage 6: accumulate
  logic               done6_r;
  logic signed [51:0] acc6_r [INFLUENCES];

  always_ff @(posedge clk) begin
    if (v5_r) begin
      for (int a = 0; a < INFLUENCES; a++) begin
        acc6_r[a] <= first5_r ? 52'(wp5_r[a]) : acc6_r[a] + 52'(wp5_r[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      done6_r <= 1'b0;
    end else begin
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      done6_r <= v5_r && last5_r;
    end
  end

  // stage 7: final rounding into the result queue
  logic signed [51:0] fin [INFLUENCES];
  result_t            res;

  always_comb begin
    for (int a = 0; a < INFLUENCES; a++) begin
      fin[a] = (acc6_r[a] + 52'sd16384) >>> 15;
    end
    res.x      = sat32(64'(fin[0]));
    res.y      = sat32(64'(fin[1]));
    res.z      = sat32(64'(fin[2]));
    res.margin = sat32(64'(fin[3]));
  end

  result_t     ofifo [OUT_DEPTH];
  logic [OW-1:0] owp_r, owp_nxt, orp_r, orp_nxt;
  logic [OW:0]   ocnt_r, ocnt_nxt;

  assign out_valid  = ocnt_r != '0;
  assign out_result = ofifo[orp_r];

  always_comb begin
    owp_nxt  = done6_r ? owp_r + 1'b1 : owp_r;
    orp_nxt  = out_fire ? orp_r + 1'b1 : orp_r;
    ocnt_nxt = ocnt_r + (OW+1)'(done6_r) - (OW+1)'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done6_r) begin
      ofifo[owp_r] <= res;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lbvs_checker.sv =====
// Port-level checker for the skinning core, bound to the top level.
`default_nettype none
module lbvs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_skinned_x,
  input wire logic [31:0] out_skinned_margin
);

  a_reset_out_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_skinned_x) &&
      $stable(out_skinned_margin))
    else $error("stalled result transaction changed");

endmodule

bind linear_blend_vertex_skinning_core lbvs_checker u_lbvs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_skinned_x      (out_skinned_x),
  .out_skinned_margin (out_skinned_margin)
);
`default_nettype wire
